>>> hdl/gsa_pkg.sv
// ----------------------------------------------------------------------------
// gsa_pkg
// shared types and constants of the generational slot allocator
// ----------------------------------------------------------------------------
package gsa_pkg;

	localparam int SLOTS     = 1024;
	localparam int GEN_W     = 16;
	localparam int IDX_W     = $clog2(SLOTS);
	localparam int LINK_W    = $clog2(SLOTS + 1);
	localparam int CNT_W     = $clog2(SLOTS + 1);

	localparam int FUNC_W    = 2;
	localparam int SLOT_ID_W = 11;
	localparam int TAG_W     = 16;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 11;

	localparam int IN_BITS   = FUNC_W + SLOT_ID_W + TAG_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = 1 + STATUS_W + SLOT_ID_W + TAG_W + COUNT_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC   = 2'd0,
		FN_RELEASE = 2'd1,
		FN_RESOLVE = 2'd2,
		FN_RESOLVE_ALT = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_NO_FREE = 3'd1,
		ST_RANGE   = 3'd2,
		ST_EMPTY   = 3'd3,
		ST_GEN     = 3'd4
	} status_t;

	typedef struct packed {
		logic              occ;
		logic [LINK_W-1:0] link;
		logic [GEN_W-1:0]  gen;
	} slot_t;

	typedef struct packed {
		logic [TAG_W-1:0]     tag;
		logic [SLOT_ID_W-1:0] slot_id;
		logic [FUNC_W-1:0]    func;
	} op_t;

	typedef struct packed {
		logic [COUNT_W-1:0]   in_use_count;
		logic [TAG_W-1:0]     handle_generation;
		logic [SLOT_ID_W-1:0] handle_id;
		status_t              status;
		logic                 ok;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		slot_t             wdata;
		logic [LINK_W-1:0] head_nxt;
		logic [CNT_W-1:0]  fill_nxt;
		logic [CNT_W-1:0]  total_nxt;
		result_t           res;
	} exec_t;

endpackage

>>> hdl/generational_slot_allocator.sv
// ----------------------------------------------------------------------------
// generational_slot_allocator
// handle table with generation tags and a free list: allocate, release, resolve
// ----------------------------------------------------------------------------
// One result beat for every input beat, in order. A new beat is taken every
// clock cycle unless the result stream stalls; each beat passes the input
// register, then the slot ram read, then the result register. Each operation
// does one read and at most one write of a single-port-pair slot ram, and the
// write of one operation is bypassed to the next, so back-to-back handles on
// the same slot see fresh contents. Slots at or above a fill mark read as their
// reset contents, so no clearing pass is needed after reset.
module generational_slot_allocator import gsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // func, slot_id, generation_tag
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // ok, status, handle_id, handle_generation, in_use_count
);

	logic              valid_s1;
	op_t               op_s1;
	logic              valid_s2;
	op_t               op_s2;
	slot_t             rd_entry;
	logic              byp_valid_q;
	logic [IDX_W-1:0]  byp_addr_q;
	slot_t             byp_data_q;
	logic [LINK_W-1:0] free_head_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  total_q;
	result_t           res_q;

	exec_t             ex;
	logic              commit;
	logic              rd_en;
	logic [LINK_W-1:0] head_fwd;
	logic [IDX_W-1:0]  raddr;
	logic              wr_en;

	assign commit   = valid_s2 && (!m_tvalid || m_tready);
	assign rd_en    = valid_s1 && (!valid_s2 || commit);
	assign s_tready = !valid_s1 || rd_en;
	assign wr_en    = commit && ex.we;
	assign head_fwd = commit ? ex.head_nxt : free_head_q;
	assign raddr    = (op_s1.func == FN_ALLOC) ? head_fwd[IDX_W-1:0]
	                                           : IDX_W'(op_s1.slot_id - SLOT_ID_W'(1));
	assign m_tdata  = OUT_DATA_W'(res_q);

	gsa_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ex.waddr),
		.wdata (ex.wdata),
		.re    (rd_en),
		.raddr (raddr),
		.rdata (rd_entry)
	);

	gsa_exec u_exec (
		.op        (op_s2),
		.rd_entry  (rd_entry),
		.byp_valid (byp_valid_q),
		.byp_addr  (byp_addr_q),
		.byp_data  (byp_data_q),
		.free_head (free_head_q),
		.fill      (fill_q),
		.total     (total_q),
		.ex        (ex)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			byp_valid_q <= 1'b0;
			free_head_q <= '0;
			fill_q      <= '0;
			total_q     <= '0;
			m_tvalid    <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (rd_en) begin
				valid_s2    <= 1'b1;
				byp_valid_q <= wr_en;
			end else if (commit) begin
				valid_s2 <= 1'b0;
			end
			if (commit) begin
				free_head_q <= ex.head_nxt;
				fill_q      <= ex.fill_nxt;
				total_q     <= ex.total_nxt;
				m_tvalid    <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1 <= op_t'(s_tdata[IN_BITS-1:0]);
		end
		if (rd_en) begin
			op_s2      <= op_s1;
			byp_addr_q <= ex.waddr;
			byp_data_q <= ex.wdata;
		end
		if (commit) begin
			res_q <= ex.res;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(SLOTS))
		else $error("occupied count beyond table size");

	a_count_fill: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= fill_q)
		else $error("occupied count beyond fill mark");

	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_q.ok == (res_q.status == ST_OK)))
		else $error("ok flag disagrees with status");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q <= LINK_W'(SLOTS))
		else $error("free head out of range");

endmodule

>>> hdl/gsa_ram.sv
// ----------------------------------------------------------------------------
// gsa_ram
// generic single-write single-read ram, registered read, old data on collision
// ----------------------------------------------------------------------------
module gsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/gsa_exec.sv
// ----------------------------------------------------------------------------
// gsa_exec
// handle check, slot update and free-list step for the operation in stage two
// ----------------------------------------------------------------------------
module gsa_exec import gsa_pkg::*; (
	input  op_t               op,
	input  slot_t             rd_entry,
	input  logic              byp_valid,
	input  logic [IDX_W-1:0]  byp_addr,
	input  slot_t             byp_data,
	input  logic [LINK_W-1:0] free_head,
	input  logic [CNT_W-1:0]  fill,
	input  logic [CNT_W-1:0]  total,
	output exec_t             ex
);

	localparam logic [GEN_W-1:0] GEN_ONE = GEN_W'(1);
	localparam logic [GEN_W-1:0] GEN_MAX = '1;

	logic             is_alloc;
	logic             is_release;
	logic             list_empty;
	logic             id_bad;
	logic [IDX_W-1:0] idx;
	logic             untouched;
	slot_t            entry;
	logic [GEN_W-1:0] alloc_gen;
	logic [GEN_W-1:0] next_gen;
	status_t          chk;

	always_comb begin
		is_alloc   = (op.func == FN_ALLOC);
		is_release = (op.func == FN_RELEASE);
		list_empty = (free_head >= LINK_W'(SLOTS));
		id_bad     = (op.slot_id == '0) || (op.slot_id > SLOT_ID_W'(SLOTS));
		idx        = is_alloc ? free_head[IDX_W-1:0] : IDX_W'(op.slot_id - SLOT_ID_W'(1));
		untouched  = (CNT_W'(idx) >= fill);

		// slots past the fill mark still hold their reset contents
		if (untouched) begin
			entry.occ  = 1'b0;
			entry.link = LINK_W'(idx) + LINK_W'(1);
			entry.gen  = GEN_ONE;
		end else if (byp_valid && byp_addr == idx) begin
			entry = byp_data;
		end else begin
			entry = rd_entry;
		end

		alloc_gen = (entry.gen == '0) ? GEN_ONE : entry.gen;
		next_gen  = (entry.gen == GEN_MAX) ? GEN_ONE : entry.gen + GEN_ONE;

		if (id_bad) begin
			chk = ST_RANGE;
		end else if (!entry.occ) begin
			chk = ST_EMPTY;
		end else if (TAG_W'(entry.gen) != op.tag) begin
			chk = ST_GEN;
		end else begin
			chk = ST_OK;
		end

		ex.we        = 1'b0;
		ex.waddr     = idx;
		ex.wdata     = entry;
		ex.head_nxt  = free_head;
		ex.fill_nxt  = fill;
		ex.total_nxt = total;
		ex.res.ok                = 1'b0;
		ex.res.status            = chk;
		ex.res.handle_id         = '0;
		ex.res.handle_generation = '0;

		if (is_alloc) begin
			if (list_empty) begin
				ex.res.status = ST_NO_FREE;
			end else begin
				ex.we         = 1'b1;
				ex.wdata.occ  = 1'b1;
				ex.wdata.link = LINK_W'(SLOTS);
				ex.wdata.gen  = alloc_gen;
				ex.head_nxt   = entry.link;
				ex.fill_nxt   = untouched ? fill + CNT_W'(1) : fill;
				ex.total_nxt  = total + CNT_W'(1);
				ex.res.status = ST_OK;
				ex.res.handle_id         = SLOT_ID_W'(idx) + SLOT_ID_W'(1);
				ex.res.handle_generation = TAG_W'(alloc_gen);
			end
		end else if (is_release) begin
			if (chk == ST_OK) begin
				ex.we         = 1'b1;
				ex.wdata.occ  = 1'b0;
				ex.wdata.link = free_head;
				ex.wdata.gen  = next_gen;
				ex.head_nxt   = LINK_W'(idx);
				ex.total_nxt  = (total != '0) ? total - CNT_W'(1) : total;
			end
		end else begin
			if (chk == ST_OK) begin
				ex.res.handle_id         = op.slot_id;
				ex.res.handle_generation = TAG_W'(entry.gen);
			end
		end

		ex.res.ok           = (ex.res.status == ST_OK);
		ex.res.in_use_count = COUNT_W'(ex.total_nxt);
	end

endmodule

>>> bench/gsa_result_checker.sv
// ----------------------------------------------------------------------------
// gsa_result_checker
// watches both streams of the slot allocator, predicts every result beat from
// its own copy of the handle table and free list, and compares field by field
// ----------------------------------------------------------------------------
module gsa_result_checker import gsa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // func, slot_id, generation_tag
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,  // ok, status, handle_id, handle_generation, in_use_count
	output int                    mismatches,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ID_LSB  = FUNC_W;
	localparam int TAG_LSB = FUNC_W + SLOT_ID_W;
	localparam int PRINT_CAP = 50;

	logic [GEN_W-1:0]  slot_gen  [SLOTS];
	logic [LINK_W-1:0] slot_link [SLOTS];
	logic              slot_occ  [SLOTS];
	logic [LINK_W-1:0] free_head;
	logic [CNT_W-1:0]  occupied;

	result_t want_results[$];
	result_t got;
	result_t want;

	task automatic report_mismatch(string what, int unsigned got_v, int unsigned want_v);
		if (mismatches < PRINT_CAP) begin
			$display("%0t: %s got %0d, expected %0d", $time, what, got_v, want_v);
		end
		mismatches++;
	endtask

	function automatic status_t handle_check(logic [SLOT_ID_W-1:0] id,
			logic [TAG_W-1:0] tag);
		logic [IDX_W-1:0] idx;
		if (id == 0 || id > SLOTS) return ST_RANGE;
		idx = IDX_W'(id - 1'b1);
		if (!slot_occ[idx]) return ST_EMPTY;
		if (slot_gen[idx] != tag) return ST_GEN;
		return ST_OK;
	endfunction

	// applies one operation to the table copy and returns the result it gives
	function automatic result_t table_apply(func_t f, logic [SLOT_ID_W-1:0] id,
			logic [TAG_W-1:0] tag);
		result_t          r;
		logic [IDX_W-1:0] idx;
		status_t          st;
		r = '0;
		st = ST_OK;
		idx = IDX_W'(id - 1'b1);
		if (f == FN_ALLOC) begin
			if (free_head >= SLOTS) begin
				st = ST_NO_FREE;
			end else begin
				idx = free_head[IDX_W-1:0];
				free_head = slot_link[idx];
				if (slot_gen[idx] == '0) slot_gen[idx] = GEN_W'(1);
				slot_occ[idx] = 1'b1;
				slot_link[idx] = LINK_W'(SLOTS);
				occupied++;
				r.handle_id = SLOT_ID_W'(idx + 1);
				r.handle_generation = slot_gen[idx];
			end
		end else if (f == FN_RELEASE) begin
			st = handle_check(id, tag);
			if (st == ST_OK) begin
				slot_occ[idx] = 1'b0;
				if (slot_gen[idx] == {GEN_W{1'b1}}) slot_gen[idx] = GEN_W'(1);
				else slot_gen[idx] = slot_gen[idx] + 1'b1;
				slot_link[idx] = free_head;
				free_head = LINK_W'(idx);
				if (occupied > 0) occupied--;
			end
		end else begin
			// both remaining selectors resolve
			st = handle_check(id, tag);
			if (st == ST_OK) begin
				r.handle_id = SLOT_ID_W'(idx + 1);
				r.handle_generation = slot_gen[idx];
			end
		end
		r.ok = (st == ST_OK);
		r.status = st;
		r.in_use_count = COUNT_W'(occupied);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			want_results.delete();
			for (int i = 0; i < SLOTS; i++) begin
				slot_gen[i] = GEN_W'(1);
				slot_link[i] = LINK_W'(i + 1);
				slot_occ[i] = 1'b0;
			end
			free_head = '0;
			occupied = '0;
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				want_results.push_back(table_apply(func_t'(s_tdata[FUNC_W-1:0]),
					s_tdata[ID_LSB +: SLOT_ID_W], s_tdata[TAG_LSB +: TAG_W]));
			end
			if (m_tvalid && m_tready) begin
				if (want_results.size() == 0) begin
					report_mismatch("result beat with nothing pending:", 1, 0);
				end else begin
					want = want_results.pop_front();
					got = m_tdata[OUT_BITS-1:0];
					if (got.ok != want.ok)
						report_mismatch("ok", got.ok, want.ok);
					if (got.status != want.status)
						report_mismatch("status", got.status, want.status);
					if (got.handle_id != want.handle_id)
						report_mismatch("handle_id", got.handle_id, want.handle_id);
					if (got.handle_generation != want.handle_generation)
						report_mismatch("handle_generation", got.handle_generation,
							want.handle_generation);
					if (got.in_use_count != want.in_use_count)
						report_mismatch("in_use_count", got.in_use_count, want.in_use_count);
					if (m_tdata[OUT_DATA_W-1:OUT_BITS] != '0)
						report_mismatch("padding", m_tdata[OUT_DATA_W-1:OUT_BITS], 0);
				end
			end
			outstanding = want_results.size();
		end
	end

endmodule

>>> bench/generational_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// generational_slot_allocator_tb
// drives allocate, release and resolve beats into the slot allocator: a short
// directed run over the checks and corner cases, one slot stepped through a
// run of generations, then random traffic that fills and drains the table, all
// under random receiver stalls, the random traffic also under random sender gaps; a checker module does the comparing
// ----------------------------------------------------------------------------
module generational_slot_allocator_tb import gsa_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_OPS = 1600;
	localparam int WRAP_ROUNDS = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG = 2000;
	localparam int DRAIN_PAD = 8;
	localparam int DEAD_KEEP = 64;

	typedef struct packed {
		logic [SLOT_ID_W-1:0] id;
		logic [TAG_W-1:0]     gen;
	} handle_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	int mismatches;
	int outstanding;

	func_t   issued_funcs[$];
	handle_t live[$];
	handle_t dead[$];
	bit      learn;
	bit      hold_req;
	int      n_ops;
	int      n_wrap_ops;
	int      n_results;
	int      status_seen[8];
	int      peak_use;
	int      stall_cycles;
	func_t   done_func;
	result_t beat;
	handle_t fresh;

	generational_slot_allocator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	gsa_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// entered and left at a falling edge
	task automatic push_op(func_t f, logic [SLOT_ID_W-1:0] id, logic [TAG_W-1:0] tag);
		s_tdata <= IN_DATA_W'({tag, id, f});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		issued_funcs.push_back(f);
		n_ops++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_PAD) @(negedge clk);
	endtask

	// result tally, and handles learnt from successful allocate results
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			done_func = FN_ALLOC;
			if (issued_funcs.size() > 0) done_func = issued_funcs.pop_front();
			beat = m_tdata[OUT_BITS-1:0];
			n_results++;
			status_seen[beat.status]++;
			if (beat.in_use_count > peak_use) peak_use = beat.in_use_count;
			if (learn && done_func == FN_ALLOC && beat.ok) begin
				fresh.id = beat.handle_id;
				fresh.gen = beat.handle_generation;
				live.push_back(fresh);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == WATCHDOG) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int mode;
		int span;
		bit hold_done;
		m_tready = 1'b0;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(4, 60);
				repeat (span) begin
					@(negedge clk);
					case (mode)
						0: begin
							m_tready <= 1'b1;
						end
						1: begin
							m_tready <= $urandom_range(0, 1);
						end
						2: begin
							m_tready <= ($urandom_range(0, 3) == 0);
						end
						default: begin
							m_tready <= ~m_tready;
						end
					endcase
				end
			end
		end
	end

	initial begin
		int pick;
		int k;
		int gap;
		int burst_left;
		int overfill;
		bit filling;
		handle_t h;
		logic [TAG_W-1:0] g;
		func_t f;

		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		learn = 1'b0;
		hold_req = 1'b0;
		n_ops = 0;
		n_wrap_ops = 0;
		n_results = 0;
		peak_use = 0;
		stall_cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// range, occupancy and generation checks in order, both resolve codes
		push_op(FN_RESOLVE, 0, 0);
		push_op(FN_RELEASE, 2047, 16'hFFFF);
		push_op(FN_RESOLVE, SLOTS + 1, 1);
		push_op(FN_RELEASE, SLOTS, 1);
		push_op(FN_RESOLVE, 1, 0);
		push_op(FN_ALLOC, 2047, 16'hFFFF);
		push_op(FN_ALLOC, 0, 0);
		push_op(FN_RESOLVE, 1, 1);
		push_op(FN_RESOLVE_ALT, 1, 1);
		push_op(FN_RESOLVE, 2, 16'hFFFF);
		push_op(FN_RELEASE, 1, 2);
		push_op(FN_RELEASE, 1, 1);
		push_op(FN_RELEASE, 1, 1);
		push_op(FN_RESOLVE_ALT, 1, 2);
		push_op(FN_ALLOC, 1234, 16'h5A5A);
		push_op(FN_RESOLVE, 1, 2);
		push_op(FN_RELEASE, 2, 1);
		push_op(FN_RESOLVE_ALT, 0, 16'hFFFF);
		push_op(FN_RESOLVE, 2, 1);
		push_op(FN_RELEASE, 1, 0);
		push_op(FN_RESOLVE, SLOTS + 1, 2);
		wait_drained();

		h.id = 1;
		h.gen = 1;
		dead.push_back(h);
		h.id = 2;
		dead.push_back(h);

		// slot 1 released and taken back again, one generation step per round
		g = 2;
		repeat (WRAP_ROUNDS) begin
			push_op(FN_RELEASE, 1, g);
			g = (g == {TAG_W{1'b1}}) ? TAG_W'(1) : g + 1'b1;
			push_op(FN_ALLOC, $urandom_range(0, 2047), $urandom_range(0, 65535));
			n_wrap_ops += 2;
		end
		wait_drained();

		h.id = 1;
		h.gen = g;
		live.push_back(h);

		learn = 1'b1;
		hold_req = 1'b1;
		filling = 1'b1;
		overfill = 0;
		burst_left = 0;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst_left--;
			if (filling && live.size() >= SLOTS) begin
				filling = 1'b0;
				overfill = 8;
			end
			pick = $urandom_range(0, 99);
			if (overfill > 0) begin
				overfill--;
				pick = 0;
			end else if (!filling) begin
				// draining: shift the weights towards release
				pick = (pick < 15) ? 0 : (pick < 75) ? 90 : (pick < 87) ? 94 : pick;
			end else begin
				pick = (pick < 85) ? 0 : (pick < 89) ? 90 : pick;
			end
			if (pick >= 90 && pick < 97 && live.size() == 0) pick = 0;

			if (pick < 90) begin
				push_op(FN_ALLOC, $urandom_range(0, 2047), $urandom_range(0, 65535));
			end else if (pick < 94) begin
				k = $urandom_range(0, live.size() - 1);
				h = live[k];
				live[k] = live[live.size() - 1];
				live.delete(live.size() - 1);
				dead.push_back(h);
				if (dead.size() > DEAD_KEEP) dead.delete(0);
				push_op(FN_RELEASE, h.id, h.gen);
			end else if (pick < 97) begin
				h = live[$urandom_range(0, live.size() - 1)];
				push_op($urandom_range(0, 1) ? FN_RESOLVE : FN_RESOLVE_ALT, h.id, h.gen);
			end else if (pick < 99) begin
				// stale handle: an old generation, or a live slot with a wrong tag
				if (dead.size() > 0 && ($urandom_range(0, 1) || live.size() == 0)) begin
					h = dead[$urandom_range(0, dead.size() - 1)];
				end else if (live.size() > 0) begin
					h = live[$urandom_range(0, live.size() - 1)];
					h.gen = h.gen ^ TAG_W'($urandom_range(1, 65535));
				end else begin
					h.id = $urandom_range(1, SLOTS);
					h.gen = $urandom_range(0, 65535);
				end
				f = func_t'($urandom_range(1, 3));
				push_op(f, h.id, h.gen);
			end else begin
				f = func_t'($urandom_range(0, 3));
				push_op(f, $urandom_range(0, 2047), $urandom_range(0, 65535));
			end
		end
		wait_drained();

		$display("run covered %0d operations and %0d results, %0d of them stepping one slot",
			n_ops, n_results, n_wrap_ops);
		$display("through its generations; ok %0d, no free %0d, range %0d, empty %0d, stale %0d",
			status_seen[ST_OK], status_seen[ST_NO_FREE], status_seen[ST_RANGE],
			status_seen[ST_EMPTY], status_seen[ST_GEN]);
		$display("table filled to a peak of %0d slots", peak_use);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
